// ===== design/wps_pkg.sv =====
// ----------------------------------------------------------------------------
// wps_pkg: shared definitions for the weighted priority select
// Sequencer states, opcodes, status codes, register indexes and score
// constants used by the queue block.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int FX_W    = 13;   // fixed point fraction field, 4096 is 1.0
    localparam int TAG_W   = 16;
    localparam int KIND_W  = 3;
    localparam int AGE_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [FX_W-1:0]  ONE_FX       = 13'd4096;
    localparam logic [AGE_W-1:0] AGE_LIMIT_MS = 16'd5000;

    // bonus = floor(d * 256 / 3125) = (d * RECIP) >> RECIP_SHIFT for d <= 5000
    localparam int MUL_A_W     = 21;
    localparam int MUL_B_W     = 13;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT = 24;
    localparam logic [MUL_A_W-1:0] RECIP = 21'd1374390;

    localparam int ACC_W   = 28;   // sum of three 13x13 products
    localparam int FRAC_SH = 12;

    localparam logic [FX_W-1:0] W_SAL_RESET = 13'd1638;
    localparam logic [FX_W-1:0] W_CER_RESET = 13'd1229;
    localparam logic [FX_W-1:0] W_NOV_RESET = 13'd1229;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_W_SAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_W_CER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_W_NOV = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_SAL,
        S_MUL_CER,
        S_MUL_NOV,
        S_MUL_AGE,
        S_SUM,
        S_INS_RD,
        S_INS_CMP,
        S_POP_RD,
        S_POP_HEAD,
        S_POP_SH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FX_W-1:0]   score;
        logic [TAG_W-1:0]  tag;
        logic [KIND_W-1:0] kind;
    } t_entry;

endpackage

// ===== design/weighted_priority_select.sv =====
// ----------------------------------------------------------------------------
// weighted_priority_select: bounded priority queue of scored requests
// Submits are scored and inserted in order, pops return the best entry.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one command beat: submit, pop,
// clear or no operation. Output channel o_out_valid / i_out_stall returns
// exactly one result beat per command, in order.
// Config writes use i_cfg_valid / o_cfg_ready; ready is always high. The user
// must make writes only while no command is in flight; the block does not enforce this.
// A submit runs the score through one shared 21x13 multiplier in four
// passes, then walks the queue from the tail, moving one entry per cycle
// through the entry memory (one read and one write a cycle). A pop reads
// the head and moves the rest up one entry per cycle. Clear, no operation,
// a submit to a full queue and a pop of an empty queue go straight to the
// done state. Each command passes through the done state and back to idle
// before the next one is accepted.
// o_in_stall is high while a command is being worked on, one command at a
// time. The result sits in an output register; the next command is taken
// while it waits, and finishing that command holds until the register frees.
// Reset empties the queue and loads the default weights; entry memory is not
// cleared.
// ----------------------------------------------------------------------------
module weighted_priority_select #(
    parameter int CAPACITY = wps_pkg::CAPACITY_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [wps_pkg::FX_W-1:0]      i_salience,
    input  logic [wps_pkg::FX_W-1:0]      i_certainty,
    input  logic [wps_pkg::FX_W-1:0]      i_newness,
    input  logic [wps_pkg::AGE_W-1:0]     i_age_ms,
    input  logic [wps_pkg::TAG_W-1:0]     i_tag,
    input  logic [wps_pkg::KIND_W-1:0]    i_module_kind,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [wps_pkg::TAG_W-1:0]     o_winner_tag,
    output logic [wps_pkg::KIND_W-1:0]    o_winner_kind,
    output logic [wps_pkg::FX_W-1:0]      o_winner_score,
    output logic [4:0]                    o_backlog,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wps_pkg::FX_W-1:0]      i_cfg_data
);
    import wps_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state r_state, n_state;

    logic [FX_W-1:0]   r_w_sal, r_w_cer, r_w_nov;
    logic [1:0]        r_op;
    logic [FX_W-1:0]   r_sal, r_cer, r_nov;
    logic [AGE_W-1:0]  r_age;
    logic [TAG_W-1:0]  r_tag;
    logic [KIND_W-1:0] r_kind;
    logic [FX_W-1:0]   r_score;

    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_idx;

    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;

    t_entry            r_queue [CAPACITY];
    t_entry            r_rd;

    logic [1:0]        r_res_status;
    t_entry            r_res;

    logic              r_out_valid;
    logic [1:0]        r_o_status;
    t_entry            r_o_win;
    logic [4:0]        r_o_count;

    logic              w_accept;
    logic              w_full;
    logic              w_out_free;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [AGE_W-1:0]  w_age_c;
    logic [AGE_W-1:0]  w_dist_full;
    logic [FX_W-1:0]   w_dist;
    logic [ACC_W-FRAC_SH:0] w_raw;
    logic [FX_W-1:0]   w_score;
    logic              w_shift;
    logic              w_more;
    t_entry            w_new;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_entry            w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // recency bonus distance
    assign w_age_c     = (r_age < AGE_LIMIT_MS) ? r_age : AGE_LIMIT_MS;
    assign w_dist_full = AGE_LIMIT_MS - w_age_c;
    assign w_dist      = w_dist_full[FX_W-1:0];

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_MUL_SAL: begin
                w_mul_a = MUL_A_W'(r_w_sal);
                w_mul_b = r_sal;
            end
            S_MUL_CER: begin
                w_mul_a = MUL_A_W'(r_w_cer);
                w_mul_b = r_cer;
            end
            S_MUL_NOV: begin
                w_mul_a = MUL_A_W'(r_w_nov);
                w_mul_b = r_nov;
            end
            S_MUL_AGE: begin
                w_mul_a = RECIP;
                w_mul_b = w_dist;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // r_acc holds the weighted sum, r_prod the bonus product in S_SUM
    assign w_raw   = (ACC_W-FRAC_SH+1)'(r_acc[ACC_W-1:FRAC_SH])
                   + (ACC_W-FRAC_SH+1)'(r_prod[PROD_W-1:RECIP_SHIFT]);
    assign w_score = (w_raw > (ACC_W-FRAC_SH+1)'(ONE_FX)) ? ONE_FX : w_raw[FX_W-1:0];

    assign w_new   = '{score: r_score, tag: r_tag, kind: r_kind};
    assign w_shift = (r_rd.score < r_score);
    assign w_more  = (CW'(r_idx) < r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (i_opcode == OP_SUBMIT && !w_full) begin
                        n_state = S_MUL_SAL;
                    end else if (i_opcode == OP_POP && r_count != '0) begin
                        n_state = S_POP_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL_SAL:  n_state = S_MUL_CER;
            S_MUL_CER:  n_state = S_MUL_NOV;
            S_MUL_NOV:  n_state = S_MUL_AGE;
            S_MUL_AGE:  n_state = S_SUM;
            S_SUM:      n_state = S_INS_RD;
            S_INS_RD:   n_state = (r_idx == '0) ? S_DONE : S_INS_CMP;
            S_INS_CMP: begin
                if (!w_shift) begin
                    n_state = S_DONE;
                end else if (r_idx == AW'(1)) begin
                    n_state = S_INS_RD;
                end
            end
            S_POP_RD:   n_state = S_POP_HEAD;
            S_POP_HEAD: n_state = (r_count == CW'(1)) ? S_DONE : S_POP_SH;
            S_POP_SH:   n_state = w_more ? S_POP_SH : S_DONE;
            S_DONE:     n_state = w_out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = w_new;
        w_re    = 1'b0;
        w_raddr = '0;
        unique case (r_state)
            S_INS_RD: begin
                if (r_idx == '0) begin
                    w_we = 1'b1;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx - AW'(1);
                end
            end
            S_INS_CMP: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                if (w_shift) begin
                    w_wdata = r_rd;
                    if (r_idx != AW'(1)) begin
                        w_re    = 1'b1;
                        w_raddr = r_idx - AW'(2);
                    end
                end
            end
            S_POP_RD: begin
                w_re = 1'b1;
            end
            S_POP_HEAD: begin
                if (r_count != CW'(1)) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(1);
                end
            end
            S_POP_SH: begin
                w_we    = 1'b1;
                w_waddr = r_idx - AW'(1);
                w_wdata = r_rd;
                if (w_more) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_queue[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_queue[w_raddr];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op         <= i_opcode;
                    r_sal        <= i_salience;
                    r_cer        <= i_certainty;
                    r_nov        <= i_newness;
                    r_age        <= i_age_ms;
                    r_tag        <= i_tag;
                    r_kind       <= i_module_kind;
                    r_res        <= '0;
                    r_res_status <= ST_DONE;
                    if (i_opcode == OP_SUBMIT && w_full) begin
                        r_res_status <= ST_FULL;
                    end
                    if (i_opcode == OP_POP && r_count == '0) begin
                        r_res_status <= ST_EMPTY;
                    end
                end
            end
            S_MUL_CER: r_acc <= r_prod[ACC_W-1:0];
            S_MUL_NOV: r_acc <= r_acc + r_prod[ACC_W-1:0];
            S_MUL_AGE: r_acc <= r_acc + r_prod[ACC_W-1:0];
            S_SUM: begin
                r_score <= w_score;
                r_idx   <= r_count[AW-1:0];
            end
            S_INS_CMP: begin
                if (w_shift) begin
                    r_idx <= r_idx - AW'(1);
                end
            end
            S_POP_HEAD: begin
                r_res <= r_rd;
                r_idx <= AW'(1);
            end
            S_POP_SH: begin
                r_idx <= r_idx + AW'(1);
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_w_sal     <= W_SAL_RESET;
            r_w_cer     <= W_CER_RESET;
            r_w_nov     <= W_NOV_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_W_SAL: r_w_sal <= i_cfg_data;
                    CFG_W_CER: r_w_cer <= i_cfg_data;
                    CFG_W_NOV: r_w_nov <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_accept && i_opcode == OP_CLEAR) begin
                r_count <= '0;
            end
            // new entry lands in its slot
            if ((r_state == S_INS_RD && r_idx == '0) || (r_state == S_INS_CMP && !w_shift)) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == S_POP_HEAD) begin
                r_count <= r_count - CW'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_status <= r_res_status;
            r_o_win    <= r_res;
            r_o_count  <= 5'(r_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_winner_tag    = r_o_win.tag;
    assign o_winner_kind   = r_o_win.kind;
    assign o_winner_score  = r_o_win.score;
    assign o_backlog       = r_o_count;

    // assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_count == '0) || (r_count == $past(r_count) + 1'b1)
                              || (r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_winner_tag == '0)
                                                 && (o_winner_score == '0))
        else $error("empty pop carries winner data");

    a_score_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_winner_score <= ONE_FX))
        else $error("winner score above one");

    a_cmp_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> (r_idx != '0))
        else $error("insert compare at head slot");

    a_op_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_HEAD) |-> (r_op == OP_POP) && ($past(r_state) == S_POP_RD))
        else $error("pop head reached off the pop path");

endmodule
